// ===== design/acfp_pkg.sv =====
// ----------------------------------------------------------------------------
// acfp_pkg
// Shared types and constants for the actuator command frame parser.
// ----------------------------------------------------------------------------
package acfp_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned HAND_W   = 3;
  localparam int unsigned CHUTE_W  = 6;

  localparam logic [BYTE_W-1:0]  PREAMBLE_BYTE = 8'hEA;
  localparam logic [CHUTE_W-1:0] CHUTE_MASK    = 6'h3F;
  localparam logic [3:0]         NIBBLE_MASK   = 4'hF;

  localparam logic [HAND_W-1:0] HAND_OPEN  = 3'd5;
  localparam logic [HAND_W-1:0] HAND_CLOSE = 3'd6;
  localparam logic [HAND_W-1:0] HAND_HALT  = 3'd0;

  // Frame positions that carry a decoded field of their own
  localparam logic [POS_W-1:0] POS_IDLE     = 5'd0;
  localparam logic [POS_W-1:0] POS_CAMERA   = 5'd9;
  localparam logic [POS_W-1:0] POS_HAND_HI  = 5'd23;
  localparam logic [POS_W-1:0] POS_CHUTE    = 5'd24;
  localparam logic [POS_W-1:0] POS_SHOVEL_HI = 5'd26;

  // Camera choices
  localparam logic [3:0] CAM_CHOICE_TWO   = 4'd1;
  localparam logic [3:0] CAM_CHOICE_THREE = 4'd2;

  // Reset values of the configuration registers
  localparam logic [WORD_W-1:0] SERVO_LOW_RST  = 16'd1000;
  localparam logic [WORD_W-1:0] SERVO_HIGH_RST = 16'd2000;

  typedef enum logic [3:0] {
    EV_NONE     = 4'd0,
    EV_LEFT     = 4'd1,
    EV_RIGHT    = 4'd2,
    EV_CAMERA   = 4'd3,
    EV_TURRET   = 4'd4,
    EV_SHOULDER = 4'd5,
    EV_ELBOW    = 4'd6,
    EV_FOREARM  = 4'd7,
    EV_HAND     = 4'd8,
    EV_CHUTES   = 4'd9,
    EV_SHOVEL   = 4'd10,
    EV_ERROR    = 4'd11
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SERVO_LOW   = 3'd0,
    REG_SERVO_HIGH  = 3'd1,
    REG_VIDEO_ONE   = 3'd2,
    REG_VIDEO_TWO   = 3'd3,
    REG_VIDEO_THREE = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [WORD_W-1:0] servo_low;
    logic [WORD_W-1:0] servo_high;
    logic [WORD_W-1:0] video_one;
    logic [WORD_W-1:0] video_two;
    logic [WORD_W-1:0] video_three;
  } cfg_t;

  typedef struct packed {
    event_t             ev;
    logic [WORD_W-1:0]  value;
    logic [WORD_W-1:0]  video_a;
    logic [WORD_W-1:0]  video_b;
    logic [HAND_W-1:0]  hand_cmd;
    logic [CHUTE_W-1:0] chute_sel;
    logic               chute_en;
    logic [CHUTE_W-1:0] chute_a;
    logic [CHUTE_W-1:0] chute_b;
  } result_t;

endpackage

// ===== design/acfp_cfg.sv =====
// ----------------------------------------------------------------------------
// acfp_cfg
// Configuration register file: servo limits and video compare levels.
// ----------------------------------------------------------------------------
module acfp_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              wr_en,
  input  logic [acfp_pkg::CFG_IDX_W-1:0]    wr_idx,
  input  logic [acfp_pkg::WORD_W-1:0]       wr_data,
  output acfp_pkg::cfg_t                    cfg
);

  acfp_pkg::cfg_t cfg_r;
  acfp_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_idx)
        acfp_pkg::REG_SERVO_LOW:   cfg_nxt.servo_low   = wr_data;
        acfp_pkg::REG_SERVO_HIGH:  cfg_nxt.servo_high  = wr_data;
        acfp_pkg::REG_VIDEO_ONE:   cfg_nxt.video_one   = wr_data;
        acfp_pkg::REG_VIDEO_TWO:   cfg_nxt.video_two   = wr_data;
        acfp_pkg::REG_VIDEO_THREE: cfg_nxt.video_three = wr_data;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.servo_low   <= acfp_pkg::SERVO_LOW_RST;
      cfg_r.servo_high  <= acfp_pkg::SERVO_HIGH_RST;
      cfg_r.video_one   <= '0;
      cfg_r.video_two   <= '0;
      cfg_r.video_three <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== design/acfp_frame.sv =====
// ----------------------------------------------------------------------------
// acfp_frame
// Frame tracker and per-byte field decode; state moves on each step.
// ----------------------------------------------------------------------------
module acfp_frame (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic [acfp_pkg::BYTE_W-1:0]   rx_byte,
  input  logic [acfp_pkg::BYTE_W-1:0]   rx_status,
  input  acfp_pkg::cfg_t                cfg,
  output acfp_pkg::result_t             res
);

  logic [acfp_pkg::POS_W-1:0]  pos_r,  pos_nxt;
  logic [acfp_pkg::BYTE_W-1:0] low_r,  low_nxt;
  logic [acfp_pkg::WORD_W-1:0] hand_r, hand_nxt;
  logic [acfp_pkg::WORD_W-1:0] word;
  logic [acfp_pkg::CHUTE_W-1:0] sel;

  function automatic logic [acfp_pkg::WORD_W-1:0] video_pick(
    input logic [3:0]     choice,
    input acfp_pkg::cfg_t c
  );
    logic [acfp_pkg::WORD_W-1:0] v;
    v = c.video_one;
    if (choice == acfp_pkg::CAM_CHOICE_TWO)        v = c.video_two;
    else if (choice == acfp_pkg::CAM_CHOICE_THREE) v = c.video_three;
    return v;
  endfunction

  assign word = {rx_byte, low_r};
  assign sel  = rx_byte[acfp_pkg::CHUTE_W-1:0] & acfp_pkg::CHUTE_MASK;

  always_comb begin
    res      = '0;
    pos_nxt  = pos_r;
    low_nxt  = low_r;
    hand_nxt = hand_r;
    if (rx_status != '0) begin
      res.ev = acfp_pkg::EV_ERROR;
    end else begin
      case (pos_r)
        acfp_pkg::POS_IDLE: begin
          if (rx_byte == acfp_pkg::PREAMBLE_BYTE) pos_nxt = pos_r + 5'd1;
        end
        // low bytes of the sixteen-bit fields
        5'd1, 5'd3, 5'd5, 5'd7, 5'd10, 5'd12, 5'd14, 5'd16,
        5'd18, 5'd20, 5'd22, 5'd25: begin
          low_nxt = rx_byte;
          pos_nxt = pos_r + 5'd1;
        end
        5'd2: begin
          res.ev = acfp_pkg::EV_LEFT;  res.value = word;  pos_nxt = pos_r + 5'd1;
        end
        5'd4: begin
          res.ev = acfp_pkg::EV_RIGHT; res.value = word;  pos_nxt = pos_r + 5'd1;
        end
        5'd11: begin
          res.ev = acfp_pkg::EV_TURRET; res.value = word; pos_nxt = pos_r + 5'd1;
        end
        5'd13: begin
          res.ev = acfp_pkg::EV_SHOULDER; res.value = word; pos_nxt = pos_r + 5'd1;
        end
        5'd15: begin
          res.ev = acfp_pkg::EV_ELBOW; res.value = word;  pos_nxt = pos_r + 5'd1;
        end
        5'd17: begin
          res.ev = acfp_pkg::EV_FOREARM; res.value = word; pos_nxt = pos_r + 5'd1;
        end
        // pan, tilt, wrist high bytes: consumed silently
        5'd6, 5'd8, 5'd19, 5'd21: begin
          pos_nxt = pos_r + 5'd1;
        end
        acfp_pkg::POS_CAMERA: begin
          res.ev      = acfp_pkg::EV_CAMERA;
          res.video_a = video_pick(rx_byte[3:0] & acfp_pkg::NIBBLE_MASK, cfg);
          res.video_b = video_pick(rx_byte[7:4] & acfp_pkg::NIBBLE_MASK, cfg);
          pos_nxt     = pos_r + 5'd1;
        end
        acfp_pkg::POS_HAND_HI: begin
          res.ev = acfp_pkg::EV_HAND;
          if (word < cfg.servo_low)       res.value = cfg.servo_low;
          else if (word > cfg.servo_high) res.value = cfg.servo_high;
          else                            res.value = word;
          if (word > hand_r)      res.hand_cmd = acfp_pkg::HAND_CLOSE;
          else if (word < hand_r) res.hand_cmd = acfp_pkg::HAND_OPEN;
          else                    res.hand_cmd = acfp_pkg::HAND_HALT;
          hand_nxt = word;
          pos_nxt  = pos_r + 5'd1;
        end
        acfp_pkg::POS_CHUTE: begin
          res.ev        = acfp_pkg::EV_CHUTES;
          res.value     = rx_byte[7] ? cfg.servo_low : cfg.servo_high;
          res.chute_sel = sel;
          res.chute_en  = rx_byte[6];
          if (rx_byte[6]) begin
            res.chute_a = sel;
            res.chute_b = ~sel & acfp_pkg::CHUTE_MASK;
          end
          pos_nxt = pos_r + 5'd1;
        end
        acfp_pkg::POS_SHOVEL_HI: begin
          res.ev    = acfp_pkg::EV_SHOVEL;
          res.value = word;
          pos_nxt   = acfp_pkg::POS_IDLE;
        end
        default: begin
          pos_nxt = acfp_pkg::POS_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= acfp_pkg::POS_IDLE;
      low_r  <= '0;
      hand_r <= '0;
    end else if (step) begin
      pos_r  <= pos_nxt;
      low_r  <= low_nxt;
      hand_r <= hand_nxt;
    end
  end

  // A receive error never disturbs the frame state
  a_err_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    step && rx_status != '0 |=> $stable(pos_r) && $stable(low_r) && $stable(hand_r))
    else $error("frame state changed on receive error");

  // Position never leaves the frame range
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= acfp_pkg::POS_SHOVEL_HI)
    else $error("frame position out of range");

  // Hand code only comes with a hand event
  a_hand_cmd_event: assert property (@(posedge clk) disable iff (!rst_n)
    res.hand_cmd != acfp_pkg::HAND_HALT |-> res.ev == acfp_pkg::EV_HAND)
    else $error("hand code outside hand event");

endmodule

// ===== design/actuator_command_frame_parser.sv =====
// ----------------------------------------------------------------------------
// actuator_command_frame_parser
// Parses 0xEA-led 27-byte command frames, one received byte per item, and
// emits one event item per byte.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------
//  in_     | in        | in_valid / in_stall | rx_byte, rx_status
//  out_    | out       | out_valid/out_stall | event_res, value, video compares,
//          |           |                     | hand_command, chute fields
//  cfg_    | in        | cfg_valid/cfg_ready | cfg_index, cfg_data (always ready)
//
//  Throughput: one item per cycle while out_stall does not hold the result
//  register. An accepted item passes the input register, then the result
//  register, before out_valid rises.
//  The frame decode is combinational between the two registers; frame state
//  is updated when an item moves from the input to the result register.
//  Reset (synchronous, rst_n low) empties both stages, returns the frame
//  tracker to preamble hunt, and loads the register defaults.
//  out_stall holds the result register; the input register still takes an
//  item while it is empty, and in_stall rises only when both stages are full.
//
module actuator_command_frame_parser (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [acfp_pkg::BYTE_W-1:0]       in_rx_byte,
  input  logic [acfp_pkg::BYTE_W-1:0]       in_rx_status,

  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [3:0]                        out_event_res,
  output logic [acfp_pkg::WORD_W-1:0]       out_value,
  output logic [acfp_pkg::WORD_W-1:0]       out_video_a_compare,
  output logic [acfp_pkg::WORD_W-1:0]       out_video_b_compare,
  output logic [acfp_pkg::HAND_W-1:0]       out_hand_command,
  output logic [acfp_pkg::CHUTE_W-1:0]      out_chute_select,
  output logic                              out_chute_enable,
  output logic [acfp_pkg::CHUTE_W-1:0]      out_chute_a_drive,
  output logic [acfp_pkg::CHUTE_W-1:0]      out_chute_b_drive,

  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [acfp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [acfp_pkg::WORD_W-1:0]       cfg_data
);

  acfp_pkg::cfg_t    cfg;
  acfp_pkg::result_t dec_res;

  // input register
  logic                        s1_valid_r, s1_valid_nxt;
  logic [acfp_pkg::BYTE_W-1:0] s1_byte_r;
  logic [acfp_pkg::BYTE_W-1:0] s1_status_r;

  // result register
  logic                        out_valid_r, out_valid_nxt;
  acfp_pkg::result_t           res_r;

  logic out_free;  // result register can load this cycle
  logic advance;   // input-register item moves to the result register
  logic accept;

  assign cfg_ready = 1'b1;

  acfp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid & cfg_ready),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  acfp_frame u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .rx_byte   (s1_byte_r),
    .rx_status (s1_status_r),
    .cfg       (cfg),
    .res       (dec_res)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept)       s1_valid_nxt = 1'b1;
    else if (advance) s1_valid_nxt = 1'b0;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance)       out_valid_nxt = 1'b1;
    else if (out_free) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte_r   <= in_rx_byte;
      s1_status_r <= in_rx_status;
    end
    if (advance) begin
      res_r <= dec_res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_event_res       = res_r.ev;
  assign out_value           = res_r.value;
  assign out_video_a_compare = res_r.video_a;
  assign out_video_b_compare = res_r.video_b;
  assign out_hand_command    = res_r.hand_cmd;
  assign out_chute_select    = res_r.chute_sel;
  assign out_chute_enable    = res_r.chute_en;
  assign out_chute_a_drive   = res_r.chute_a;
  assign out_chute_b_drive   = res_r.chute_b;

  // Item in the input register is kept while the result register is blocked
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && out_stall |=> s1_valid_r)
    else $error("input item dropped while result stalled");

  // Accepted item always lands in the input register
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_valid_r)
    else $error("accepted item lost");

  // With nothing behind it, a taken result leaves the output empty
  a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_stall && !s1_valid_r |=> !out_valid_r)
    else $error("result repeated after being taken");

endmodule

// ===== sim/actuator_command_frame_parser_test.sv =====
// ----------------------------------------------------------------------------
// actuator_command_frame_parser_test
// Self-checking regression for the actuator command frame parser. Bytes are
// driven as whole frames, noise and receive errors. Every accepted byte is
// decoded by a local frame tracker into the event it must produce, and each
// result item is compared field by field against that event queue.
// Randomized idling on both channels, a long result hold-off, and several
// register settings (including inverted and equal servo limits) are covered.
// ----------------------------------------------------------------------------
module actuator_command_frame_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [acfp_pkg::BYTE_W-1:0]    byte_t;
  typedef logic [acfp_pkg::WORD_W-1:0]    word_t;
  typedef logic [acfp_pkg::CFG_IDX_W-1:0] idx_t;

  // Two register stages between input and result.
  localparam int RESULT_LATENCY = 2;
  // Cycles in a row with no handshake on any channel before giving up.
  localparam int WATCHDOG_LIMIT = 2000;
  // Length of the forced result hold-off in the back-pressure test.
  localparam int HOLD_CYCLES    = 64;
  localparam int FRAME_LEN      = 27;
  localparam int RANDOM_FRAMES  = 6;

  // One frame worth of field values, in wire order.
  typedef struct {
    word_t left;
    word_t right;
    word_t pan;
    word_t tilt;
    byte_t camera;
    word_t turret;
    word_t shoulder;
    word_t elbow;
    word_t forearm;
    word_t wrist;
    word_t wrist_roll;
    word_t hand;
    byte_t chute;
    word_t shovel;
  } frame_t;

  logic                                 clk;
  logic                                 rst_n;
  logic                                 in_valid;
  logic                                 in_stall;
  byte_t                                in_rx_byte;
  byte_t                                in_rx_status;
  logic                                 out_valid;
  logic                                 out_stall;
  logic [3:0]                           out_event_res;
  word_t                                out_value;
  word_t                                out_video_a_compare;
  word_t                                out_video_b_compare;
  logic [acfp_pkg::HAND_W-1:0]          out_hand_command;
  logic [acfp_pkg::CHUTE_W-1:0]         out_chute_select;
  logic                                 out_chute_enable;
  logic [acfp_pkg::CHUTE_W-1:0]         out_chute_a_drive;
  logic [acfp_pkg::CHUTE_W-1:0]         out_chute_b_drive;
  logic                                 cfg_valid;
  logic                                 cfg_ready;
  idx_t                                 cfg_index;
  word_t                                cfg_data;

  // Local copy of the parser: registers and frame tracker.
  acfp_pkg::cfg_t               regs;
  logic [acfp_pkg::POS_W-1:0]   frame_pos;
  byte_t                        held_low_byte;
  word_t                        prev_hand_target;

  // Events still owed by the block, oldest first.
  acfp_pkg::result_t expected_events[$];

  int failures;
  int quiet_cycles;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_count;
  bit hold_request;

  actuator_command_frame_parser uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_rx_byte          (in_rx_byte),
    .in_rx_status        (in_rx_status),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_event_res       (out_event_res),
    .out_value           (out_value),
    .out_video_a_compare (out_video_a_compare),
    .out_video_b_compare (out_video_b_compare),
    .out_hand_command    (out_hand_command),
    .out_chute_select    (out_chute_select),
    .out_chute_enable    (out_chute_enable),
    .out_chute_a_drive   (out_chute_a_drive),
    .out_chute_b_drive   (out_chute_b_drive),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Frame tracker
  // --------------------------------------------------------------------------

  // Camera nibble to compare level; anything past the third choice falls
  // back to the first level.
  function automatic word_t video_level(input logic [3:0] choice);
    if (choice == acfp_pkg::CAM_CHOICE_TWO) return regs.video_two;
    if (choice == acfp_pkg::CAM_CHOICE_THREE) return regs.video_three;
    return regs.video_one;
  endfunction

  // Decode one accepted byte, advance the tracker, return the event it owes.
  function automatic acfp_pkg::result_t decode_byte(input byte_t b,
                                                    input byte_t status);
    acfp_pkg::result_t            r;
    word_t                        word;
    logic [acfp_pkg::CHUTE_W-1:0] sel;
    r    = '0;
    word = {b, held_low_byte};
    // A receive error reports and leaves the tracker alone.
    if (status != '0) begin
      r.ev = acfp_pkg::EV_ERROR;
      return r;
    end
    case (frame_pos)
      acfp_pkg::POS_IDLE: begin
        if (b == acfp_pkg::PREAMBLE_BYTE) frame_pos = 5'd1;
      end
      // Low bytes of every sixteen-bit field
      5'd1, 5'd3, 5'd5, 5'd7, 5'd10, 5'd12, 5'd14, 5'd16, 5'd18, 5'd20, 5'd22,
      5'd25: begin
        held_low_byte = b;
        frame_pos     = frame_pos + 5'd1;
      end
      5'd2, 5'd4, 5'd11, 5'd13, 5'd15, 5'd17: begin
        case (frame_pos)
          5'd2:    r.ev = acfp_pkg::EV_LEFT;
          5'd4:    r.ev = acfp_pkg::EV_RIGHT;
          5'd11:   r.ev = acfp_pkg::EV_TURRET;
          5'd13:   r.ev = acfp_pkg::EV_SHOULDER;
          5'd15:   r.ev = acfp_pkg::EV_ELBOW;
          default: r.ev = acfp_pkg::EV_FOREARM;
        endcase
        r.value   = word;
        frame_pos = frame_pos + 5'd1;
      end
      // Pan, tilt and wrist high bytes: consumed only, no event
      5'd6, 5'd8, 5'd19, 5'd21: begin
        frame_pos = frame_pos + 5'd1;
      end
      acfp_pkg::POS_CAMERA: begin
        r.ev      = acfp_pkg::EV_CAMERA;
        r.video_a = video_level(b[3:0]);
        r.video_b = video_level(b[7:4]);
        frame_pos = frame_pos + 5'd1;
      end
      acfp_pkg::POS_HAND_HI: begin
        // With inverted limits, a target below the low limit gets the low limit and any other the high limit.
        r.ev    = acfp_pkg::EV_HAND;
        r.value = word;
        if (word < regs.servo_low) r.value = regs.servo_low;
        else if (word > regs.servo_high) r.value = regs.servo_high;
        if (word > prev_hand_target) r.hand_cmd = acfp_pkg::HAND_CLOSE;
        else if (word < prev_hand_target) r.hand_cmd = acfp_pkg::HAND_OPEN;
        else r.hand_cmd = acfp_pkg::HAND_HALT;
        prev_hand_target = word;
        frame_pos        = acfp_pkg::POS_CHUTE;
      end
      acfp_pkg::POS_CHUTE: begin
        sel         = b[acfp_pkg::CHUTE_W-1:0];
        r.ev        = acfp_pkg::EV_CHUTES;
        r.value     = b[7] ? regs.servo_low : regs.servo_high;
        r.chute_sel = sel;
        r.chute_en  = b[6];
        if (b[6]) begin
          r.chute_a = sel;
          r.chute_b = ~sel & acfp_pkg::CHUTE_MASK;
        end
        frame_pos = frame_pos + 5'd1;
      end
      acfp_pkg::POS_SHOVEL_HI: begin
        r.ev      = acfp_pkg::EV_SHOVEL;
        r.value   = word;
        frame_pos = acfp_pkg::POS_IDLE;
      end
      default: frame_pos = acfp_pkg::POS_IDLE;
    endcase
    return r;
  endfunction

  function automatic void apply_reg_write(input idx_t idx, input word_t data);
    case (idx)
      acfp_pkg::REG_SERVO_LOW:   regs.servo_low   = data;
      acfp_pkg::REG_SERVO_HIGH:  regs.servo_high  = data;
      acfp_pkg::REG_VIDEO_ONE:   regs.video_one   = data;
      acfp_pkg::REG_VIDEO_TWO:   regs.video_two   = data;
      acfp_pkg::REG_VIDEO_THREE: regs.video_three = data;
      default: ;  // unmapped index, dropped
    endcase
  endfunction

  task automatic check_field(input string field, input word_t want, input word_t got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      failures++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Scoreboard: check results first, then log new input and register items.
  // Everything is sampled at the rising edge; drivers move on the falling one.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    acfp_pkg::result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected result item, expected none, actual event %0d",
                 $time, out_event_res);
        failures++;
      end else begin
        want = expected_events.pop_front();
        check_field("event_res", word_t'(want.ev), word_t'(out_event_res));
        check_field("value", want.value, out_value);
        check_field("video_a_compare", want.video_a, out_video_a_compare);
        check_field("video_b_compare", want.video_b, out_video_b_compare);
        check_field("hand_command", word_t'(want.hand_cmd), word_t'(out_hand_command));
        check_field("chute_select", word_t'(want.chute_sel), word_t'(out_chute_select));
        check_field("chute_enable", word_t'(want.chute_en), word_t'(out_chute_enable));
        check_field("chute_a_drive", word_t'(want.chute_a), word_t'(out_chute_a_drive));
        check_field("chute_b_drive", word_t'(want.chute_b), word_t'(out_chute_b_drive));
      end
    end
    if (rst_n && in_valid && !in_stall)
      expected_events.push_back(decode_byte(in_rx_byte, in_rx_status));
    if (rst_n && cfg_valid && cfg_ready)
      apply_reg_write(cfg_index, cfg_data);
  end

  // Watchdog: any handshake counts as progress.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("actuator_command_frame_parser regression: fail");
      $finish;
    end
  end

  // Result side: random stall, or a counted hold-off when one is requested.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_count   = HOLD_CYCLES;
      end
      if (hold_count > 0) begin
        hold_count--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drivers (called at a falling edge, return at a falling edge)
  // --------------------------------------------------------------------------

  // in_valid stays high from one item to the next unless an idle gap is drawn.
  task automatic send_byte(input byte_t data, input byte_t status);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_rx_byte   <= data;
    in_rx_status <= status;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input idx_t idx, input word_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_settings(input word_t low, input word_t high,
                               input word_t lvl_one,
                               input word_t lvl_two,
                               input word_t lvl_three);
    write_reg(acfp_pkg::REG_SERVO_LOW, low);
    write_reg(acfp_pkg::REG_SERVO_HIGH, high);
    write_reg(acfp_pkg::REG_VIDEO_ONE, lvl_one);
    write_reg(acfp_pkg::REG_VIDEO_TWO, lvl_two);
    write_reg(acfp_pkg::REG_VIDEO_THREE, lvl_three);
  endtask

  // Stop offering, let every owed event come back, then allow the pipe to
  // settle before anything touches the registers.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(negedge clk);
    repeat (RESULT_LATENCY + 2) @(negedge clk);
  endtask

  function automatic byte_t noise_byte();
    byte_t b;
    do b = byte_t'($urandom); while (b == acfp_pkg::PREAMBLE_BYTE);
    return b;
  endfunction

  function automatic word_t pick_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic logic [3:0] pick_choice();
    if ($urandom_range(3) == 0) return 4'($urandom_range(3, 15));
    return 4'($urandom_range(0, 2));
  endfunction

  function automatic frame_t random_frame();
    frame_t f;
    f.left       = pick_word();
    f.right      = pick_word();
    f.pan        = pick_word();
    f.tilt       = pick_word();
    f.camera     = {pick_choice(), pick_choice()};
    f.turret     = pick_word();
    f.shoulder   = pick_word();
    f.elbow      = pick_word();
    f.forearm    = pick_word();
    f.wrist      = pick_word();
    f.wrist_roll = pick_word();
    // Bias the hand toward a repeated target (halt) and the clamp edges.
    case ($urandom_range(3))
      0:       f.hand = prev_hand_target;
      1:       f.hand = regs.servo_low + word_t'($urandom_range(0, 2)) - 16'd1;
      2:       f.hand = regs.servo_high + word_t'($urandom_range(0, 2)) - 16'd1;
      default: f.hand = pick_word();
    endcase
    f.chute  = byte_t'($urandom);
    f.shovel = pick_word();
    return f;
  endfunction

  // Sends the first `keep` bytes of a frame. A frame left unfinished earlier
  // is completed with noise first so this one lands on a preamble hunt.
  task automatic send_frame(input frame_t f, input int err_pct, input int keep);
    byte_t bytes_out[FRAME_LEN];
    bytes_out = '{acfp_pkg::PREAMBLE_BYTE,
                  f.left[7:0], f.left[15:8], f.right[7:0], f.right[15:8],
                  f.pan[7:0], f.pan[15:8], f.tilt[7:0], f.tilt[15:8],
                  f.camera,
                  f.turret[7:0], f.turret[15:8], f.shoulder[7:0], f.shoulder[15:8],
                  f.elbow[7:0], f.elbow[15:8], f.forearm[7:0], f.forearm[15:8],
                  f.wrist[7:0], f.wrist[15:8], f.wrist_roll[7:0], f.wrist_roll[15:8],
                  f.hand[7:0], f.hand[15:8],
                  f.chute,
                  f.shovel[7:0], f.shovel[15:8]};
    while (frame_pos != acfp_pkg::POS_IDLE) send_byte(noise_byte(), 8'd0);
    for (int i = 0; i < keep; i++) begin
      if ($urandom_range(99) < err_pct)
        send_byte(byte_t'($urandom), byte_t'($urandom_range(1, 255)));
      send_byte(bytes_out[i], 8'd0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Preamble hunt: near-miss bytes are dropped, errors still report, and an
  // errored preamble does not open a frame.
  task automatic test_preamble_hunt();
    send_byte(8'h00, 8'h00);
    send_byte(8'hFF, 8'h00);
    send_byte(8'hE9, 8'h00);
    send_byte(8'h6A, 8'h00);
    send_byte(acfp_pkg::PREAMBLE_BYTE, 8'hFF);
    send_byte(acfp_pkg::PREAMBLE_BYTE, 8'h01);
  endtask

  // Field extremes at reset register values; a receive error in the middle
  // of the turret field must not disturb the byte pairing.
  task automatic test_field_extremes();
    frame_t f;
    f          = random_frame();
    f.left     = 16'h0000;
    f.right    = 16'hFFFF;
    f.camera   = {acfp_pkg::CAM_CHOICE_THREE, acfp_pkg::CAM_CHOICE_TWO};
    f.turret   = 16'h8001;
    f.shoulder = 16'h7FFE;
    send_frame(f, 0, 11);
    send_byte(acfp_pkg::PREAMBLE_BYTE, 8'h80);
    send_byte(f.turret[15:8], 8'h00);
    send_byte(f.shoulder[7:0], 8'h00);
    send_byte(f.shoulder[15:8], 8'h00);
  endtask

  // Every register plus the unmapped indices, then one frame that reads the low
  // limit and the second and third levels back through hand clamp, camera compares and chute value.
  task automatic test_register_map();
    frame_t f;
    wait_for_results();
    load_settings(16'd1200, 16'd1800, 16'h1111, 16'h2222, 16'h3333);
    for (int i = int'(acfp_pkg::REG_VIDEO_THREE) + 1; i < (1 << acfp_pkg::CFG_IDX_W); i++)
      write_reg(idx_t'(i), 16'hFFFF);
    f        = random_frame();
    f.camera = {acfp_pkg::CAM_CHOICE_TWO, acfp_pkg::CAM_CHOICE_THREE};
    f.hand   = 16'd100;
    f.chute  = 8'hC5;
    f.shovel = 16'hFFFF;
    send_frame(f, 0, FRAME_LEN);
  endtask

  // Mostly clean frames with random content, each possibly preceded by line noise;
  // the rest carry errors or are cut short.
  task automatic test_random_frames();
    int pick;
    repeat (RANDOM_FRAMES) begin
      pick = $urandom_range(99);
      repeat ($urandom_range(0, 2)) send_byte(noise_byte(), 8'd0);
      if (pick < 8) send_byte(byte_t'($urandom), byte_t'($urandom_range(1, 255)));
      if (pick < 75)      send_frame(random_frame(), 0, FRAME_LEN);
      else if (pick < 90) send_frame(random_frame(), 10, FRAME_LEN);
      else                send_frame(random_frame(), 0, $urandom_range(2, FRAME_LEN - 1));
    end
  endtask

  // Hold results off long enough that both stages fill and in_stall rises
  // while frames keep coming.
  task automatic test_result_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = 1'b1;
    send_frame(random_frame(), 0, FRAME_LEN);
    send_frame(random_frame(), 0, FRAME_LEN);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_rx_byte       = '0;
    in_rx_status     = '0;
    cfg_valid        = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    failures         = 0;
    quiet_cycles     = 0;
    hold_count       = 0;
    hold_request     = 1'b0;
    send_idle_pct    = 30;
    recv_idle_pct    = 52;
    regs.servo_low   = acfp_pkg::SERVO_LOW_RST;
    regs.servo_high  = acfp_pkg::SERVO_HIGH_RST;
    regs.video_one   = '0;
    regs.video_two   = '0;
    regs.video_three = '0;
    frame_pos        = acfp_pkg::POS_IDLE;
    held_low_byte    = '0;
    prev_hand_target = '0;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_preamble_hunt();
    test_field_extremes();
    test_register_map();

    // Phase one: full-range limits, extreme video levels.
    wait_for_results();
    load_settings(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h8000);
    test_random_frames();

    // Phase two: idling swapped, inverted limits.
    wait_for_results();
    send_idle_pct = 52;
    recv_idle_pct = 30;
    load_settings(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0001);
    test_random_frames();

    // Phase three: no idling, equal limits, random levels.
    wait_for_results();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    begin : equal_limits
      word_t lim;
      lim = word_t'($urandom);
      load_settings(lim, lim, word_t'($urandom), word_t'($urandom), word_t'($urandom));
    end
    test_random_frames();

    test_result_backpressure();

    wait_for_results();
    if (failures == 0 && expected_events.size() == 0) begin
      $display("actuator_command_frame_parser regression: pass");
    end else begin
      $display("actuator_command_frame_parser regression: fail");
    end
    $finish;
  end

endmodule
